@@ rtl/core/pesp_pkg.sv @@
// Package for the PES private stream parser: phase codes, result kinds, result struct.
`timescale 1ns / 1ps

package pesp_pkg;

    localparam int PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_ZERO1   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ZERO2   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ONE     = 4'd2;
    localparam logic [PHASE_W-1:0] PH_ID      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_LENHI   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_LENLO   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_FLAGS1  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_FLAGS2  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_HDRLEN  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SKIP    = 4'd9;
    localparam logic [PHASE_W-1:0] PH_DATAID  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd11;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_HDRERR  = 2'd2;
    localparam logic [1:0] KIND_SHORT   = 2'd3;

    localparam logic       CFG_STREAM_ID  = 1'b0;
    localparam logic       CFG_HEADER_LEN = 1'b1;

    localparam logic [7:0] STREAM_ID_RST  = 8'hBD;
    localparam logic [7:0] HEADER_LEN_RST = 8'd36;
    localparam logic [8:0] HDR_FIXED      = 9'd4;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [15:0] payload_length;
        logic        last;
    } result_t;

endpackage

@@ rtl/core/pesp_core.sv @@
// Parse state, configuration registers and the per-byte parse step.
`timescale 1ns / 1ps

module pesp_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             step,
    input  logic [7:0]       stream_byte,
    output pesp_pkg::result_t res
);

    logic [pesp_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [15:0] packet_length_reg, packet_length_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  stream_id_reg, header_length_reg;
    logic [8:0]  need;
    logic        too_short;
    logic [15:0] count_dec;
    logic [15:0] payload_len;

    assign need        = {1'b0, header_length_reg} + pesp_pkg::HDR_FIXED;
    assign too_short   = {7'd0, need} > packet_length_reg;
    assign count_dec   = byte_count_reg - 16'd1;
    assign payload_len = packet_length_reg - {7'd0, need};

    always_comb
    begin
        phase_next         = phase_reg;
        packet_length_next = packet_length_reg;
        byte_count_next    = byte_count_reg;
        res                = '0;
        case (phase_reg)
            pesp_pkg::PH_ZERO1:
            begin
                if (stream_byte == 8'd0)
                    phase_next = pesp_pkg::PH_ZERO2;
            end
            pesp_pkg::PH_ZERO2:
            begin
                phase_next = (stream_byte == 8'd0) ? pesp_pkg::PH_ONE : pesp_pkg::PH_ZERO1;
            end
            pesp_pkg::PH_ONE:
            begin
                if (stream_byte == 8'd1)
                    phase_next = pesp_pkg::PH_ID;
                else if (stream_byte != 8'd0)
                    phase_next = pesp_pkg::PH_ZERO1;
            end
            pesp_pkg::PH_ID:
            begin
                if (stream_byte == stream_id_reg)
                    phase_next = pesp_pkg::PH_LENHI;
                else
                    phase_next = (stream_byte == 8'd0) ? pesp_pkg::PH_ZERO2
                                                       : pesp_pkg::PH_ZERO1;
            end
            pesp_pkg::PH_LENHI:
            begin
                packet_length_next = {stream_byte, 8'd0};
                phase_next         = pesp_pkg::PH_LENLO;
            end
            pesp_pkg::PH_LENLO:
            begin
                packet_length_next = {packet_length_reg[15:8], stream_byte};
                phase_next         = pesp_pkg::PH_FLAGS1;
            end
            pesp_pkg::PH_FLAGS1:
            begin
                phase_next = pesp_pkg::PH_FLAGS2;
            end
            pesp_pkg::PH_FLAGS2:
            begin
                phase_next = pesp_pkg::PH_HDRLEN;
            end
            pesp_pkg::PH_HDRLEN:
            begin
                if (stream_byte != header_length_reg)
                begin
                    phase_next = pesp_pkg::PH_ZERO1;
                    res.valid  = 1'b1;
                    res.kind   = pesp_pkg::KIND_HDRERR;
                    res.value  = stream_byte;
                end
                else if (too_short)
                begin
                    phase_next = pesp_pkg::PH_ZERO1;
                    res.valid  = 1'b1;
                    res.kind   = pesp_pkg::KIND_SHORT;
                    res.value  = stream_byte;
                end
                else
                begin
                    byte_count_next = {8'd0, header_length_reg};
                    phase_next      = (header_length_reg == 8'd0) ? pesp_pkg::PH_DATAID
                                                                  : pesp_pkg::PH_SKIP;
                end
            end
            pesp_pkg::PH_SKIP:
            begin
                byte_count_next = count_dec;
                if (count_dec == 16'd0)
                    phase_next = pesp_pkg::PH_DATAID;
            end
            pesp_pkg::PH_DATAID:
            begin
                res.valid = 1'b1;
                if (too_short)
                begin
                    // header length rewritten mid-packet
                    phase_next = pesp_pkg::PH_ZERO1;
                    res.kind   = pesp_pkg::KIND_SHORT;
                    res.value  = header_length_reg;
                end
                else
                begin
                    byte_count_next    = payload_len;
                    phase_next         = (payload_len == 16'd0) ? pesp_pkg::PH_ZERO1
                                                                : pesp_pkg::PH_PAYLOAD;
                    res.kind           = pesp_pkg::KIND_START;
                    res.value          = stream_byte;
                    res.payload_length = payload_len;
                end
            end
            pesp_pkg::PH_PAYLOAD:
            begin
                byte_count_next = count_dec;
                res.valid       = 1'b1;
                res.kind        = pesp_pkg::KIND_PAYLOAD;
                res.value       = stream_byte;
                if (count_dec == 16'd0)
                begin
                    phase_next = pesp_pkg::PH_ZERO1;
                    res.last   = 1'b1;
                end
            end
            default:
            begin
                phase_next = (stream_byte == 8'd0) ? pesp_pkg::PH_ZERO2 : pesp_pkg::PH_ZERO1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= pesp_pkg::PH_ZERO1;
            packet_length_reg <= 16'd0;
            byte_count_reg    <= 16'd0;
            stream_id_reg     <= pesp_pkg::STREAM_ID_RST;
            header_length_reg <= pesp_pkg::HEADER_LEN_RST;
        end
        else
        begin
            if (step)
            begin
                phase_reg         <= phase_next;
                packet_length_reg <= packet_length_next;
                byte_count_reg    <= byte_count_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    pesp_pkg::CFG_STREAM_ID:  stream_id_reg     <= cfg_data;
                    pesp_pkg::CFG_HEADER_LEN: header_length_reg <= cfg_data;
                    default:                  stream_id_reg     <= stream_id_reg;
                endcase
            end
        end
    end

endmodule

@@ rtl/core/pes_private_stream_parser.sv @@
// Top level: PES private stream parser with input and result registers.
// A result word is formed from the input register and is held in the result register.
// Throughput: one byte per cycle; the parse step is one short state update
// between the input register and the result register.
// Stalls only when the result register is full and m_tready is low.
// Reset (rst_n, async, active low) clears both registers, hunts for 00 00 01,
// and loads stream_id 0xBD and header_length 36.
`timescale 1ns / 1ps

module pes_private_stream_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] value, [23:8] payload_length
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic [23:0]       out_data_reg;
    logic [1:0]        out_kind_reg;
    logic              out_last_reg;
    logic              out_free;
    logic              advance;
    pesp_pkg::result_t res;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    pesp_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (advance),
        .stream_byte (in_byte_reg),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= advance && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (out_free)
        begin
            out_data_reg <= {res.payload_length, res.value};
            out_kind_reg <= res.kind;
            out_last_reg <= res.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/core/pesp_checker.sv @@
// Port-level checks for the PES private stream parser, bound to the top level.
`timescale 1ns / 1ps

module pesp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // last only ever marks a payload byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == pesp_pkg::KIND_PAYLOAD)
        else $error("tlast on non-payload word");

    // length field is carried only on packet start
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != pesp_pkg::KIND_START |-> m_tdata[23:8] == 16'd0)
        else $error("payload_length set on non-start word");

    // error words never carry last
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == pesp_pkg::KIND_HDRERR || m_tuser == pesp_pkg::KIND_SHORT)
        |-> !m_tlast)
        else $error("tlast on error word");

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled output word changed");

endmodule

bind pes_private_stream_parser pesp_checker u_pesp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
